// ===== src/vebc_pkg.sv =====
package vebc_pkg;

  // Default chunk geometry
  localparam int CHUNK_WIDTH_DEF  = 16;
  localparam int CHUNK_HEIGHT_DEF = 256;
  localparam int CHUNK_DEPTH_DEF  = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_X = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_Z = 1'd1;

  // Request function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_SCAN = 1'b1;

  // Neighbor read steps, center read is issued on accept
  localparam logic [2:0] STEP_XN = 3'd1;
  localparam logic [2:0] STEP_XP = 3'd2;
  localparam logic [2:0] STEP_YN = 3'd3;
  localparam logic [2:0] STEP_YP = 3'd4;
  localparam logic [2:0] STEP_ZN = 3'd5;
  localparam logic [2:0] STEP_ZP = 3'd6;

  localparam logic [1:0] KIND_AIR = 2'd0;

  typedef struct packed {
    logic       func;
    logic [3:0] cell_x;
    logic [7:0] cell_y;
    logic [3:0] cell_z;
    logic [1:0] block_kind;
  } in_req_t;

  typedef struct packed {
    logic               exposed;
    logic [1:0]         kind_out;
    logic signed [19:0] world_x;
    logic [7:0]         world_y;
    logic signed [19:0] world_z;
  } out_res_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } mem_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN
  } scan_state_t;

endpackage

// ===== src/vebc_store.sv =====
module vebc_store #(
  parameter int DEPTH = vebc_pkg::CHUNK_WIDTH_DEF * vebc_pkg::CHUNK_HEIGHT_DEF *
                        vebc_pkg::CHUNK_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic               clk,
  input  vebc_pkg::mem_cmd_t mem_cmd,
  input  logic [AW-1:0]      mem_addr,
  input  logic [1:0]         mem_wdata,
  output logic [1:0]         mem_rdata
);

  logic [1:0] mem [DEPTH];
  logic [1:0] rdata_r;

  // Single port: write or registered read
  always_ff @(posedge clk) begin
    if (mem_cmd.wr) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_cmd.rd) begin
      rdata_r <= mem[mem_addr];
    end
  end

  assign mem_rdata = rdata_r;

endmodule

// ===== src/vebc_ctrl.sv =====
module vebc_ctrl #(
  parameter int CHUNK_WIDTH  = vebc_pkg::CHUNK_WIDTH_DEF,
  parameter int CHUNK_HEIGHT = vebc_pkg::CHUNK_HEIGHT_DEF,
  parameter int CHUNK_DEPTH  = vebc_pkg::CHUNK_DEPTH_DEF,
  localparam int DEPTH = CHUNK_WIDTH * CHUNK_HEIGHT * CHUNK_DEPTH,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  vebc_pkg::in_req_t   in_req,
  input  logic signed [15:0]  chunk_x,
  input  logic signed [15:0]  chunk_z,
  output logic                out_valid,
  input  logic                out_stall,
  output vebc_pkg::out_res_t  out_res,
  output vebc_pkg::mem_cmd_t  mem_cmd,
  output logic [AW-1:0]       mem_addr,
  output logic [1:0]          mem_wdata,
  input  logic [1:0]          mem_rdata
);

  localparam logic [AW-1:0] OFF_X = AW'(CHUNK_HEIGHT * CHUNK_DEPTH);
  localparam logic [AW-1:0] OFF_Y = AW'(CHUNK_DEPTH);
  localparam logic [AW-1:0] OFF_Z = AW'(1);

  vebc_pkg::scan_state_t state_r, state_nxt;
  logic [2:0]         step_r, step_nxt;
  logic [AW-1:0]      addr_r;
  logic [3:0]         x_r;
  logic [7:0]         y_r;
  logic [3:0]         z_r;
  logic               inside_r;
  logic               face_r;
  logic [1:0]         kind_r;
  logic               air_r;
  logic               rd_vld_r;
  logic               rd_center_r;
  logic               out_valid_r, out_valid_nxt;
  vebc_pkg::out_res_t out_res_r;

  logic          accept;
  logic          is_scan;
  logic [AW-1:0] in_addr;
  logic          in_inside;
  logic          in_face;
  logic [AW-1:0] nb_addr;
  logic [1:0]    fin_kind;
  logic          fin_air;
  logic          load_out;
  vebc_pkg::out_res_t res;

  assign in_stall = (state_r != vebc_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign is_scan  = (in_req.func == vebc_pkg::FUNC_SCAN);

  // Decode the incoming cell: linear address, range check, chunk face
  always_comb begin
    in_addr = AW'(in_req.cell_x) * OFF_X + AW'(in_req.cell_y) * OFF_Y + AW'(in_req.cell_z);
    in_inside = (int'(in_req.cell_x) < CHUNK_WIDTH) &&
                (int'(in_req.cell_y) < CHUNK_HEIGHT) &&
                (int'(in_req.cell_z) < CHUNK_DEPTH);
    in_face = (in_req.cell_x == '0) || (in_req.cell_y == '0) || (in_req.cell_z == '0) ||
              (int'(in_req.cell_x) == CHUNK_WIDTH - 1) ||
              (int'(in_req.cell_y) == CHUNK_HEIGHT - 1) ||
              (int'(in_req.cell_z) == CHUNK_DEPTH - 1);
  end

  // Neighbor address for the current step
  always_comb begin
    case (step_r)
      vebc_pkg::STEP_XN: nb_addr = addr_r - OFF_X;
      vebc_pkg::STEP_XP: nb_addr = addr_r + OFF_X;
      vebc_pkg::STEP_YN: nb_addr = addr_r - OFF_Y;
      vebc_pkg::STEP_YP: nb_addr = addr_r + OFF_Y;
      vebc_pkg::STEP_ZN: nb_addr = addr_r - OFF_Z;
      vebc_pkg::STEP_ZP: nb_addr = addr_r + OFF_Z;
      default:           nb_addr = addr_r;
    endcase
  end

  // Fold in the read that may still be in flight
  always_comb begin
    fin_kind = kind_r;
    fin_air  = air_r;
    if (rd_vld_r) begin
      if (rd_center_r) begin
        fin_kind = mem_rdata;
      end else if (mem_rdata == vebc_pkg::KIND_AIR) begin
        fin_air = 1'b1;
      end
    end
    res.exposed  = inside_r && (fin_kind != vebc_pkg::KIND_AIR) && (face_r || fin_air);
    res.kind_out = inside_r ? fin_kind : vebc_pkg::KIND_AIR;
    res.world_x  = 20'(int'(chunk_x) * CHUNK_WIDTH + int'(x_r));
    res.world_y  = y_r;
    res.world_z  = 20'(int'(chunk_z) * CHUNK_WIDTH + int'(z_r));
  end

  // Sequencer: next state and memory commands
  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    mem_cmd.wr  = 1'b0;
    mem_cmd.rd  = 1'b0;
    mem_addr    = in_addr;
    mem_wdata   = in_req.block_kind;
    load_out    = 1'b0;
    case (state_r)
      vebc_pkg::ST_IDLE: begin
        mem_cmd.wr = accept && !is_scan && in_inside;
        mem_cmd.rd = accept && is_scan && in_inside;
        step_nxt   = vebc_pkg::STEP_XN;
        if (accept && is_scan) begin
          if (in_inside && !in_face) begin
            state_nxt = vebc_pkg::ST_READ;
          end else begin
            state_nxt = vebc_pkg::ST_DRAIN;
          end
        end
      end
      vebc_pkg::ST_READ: begin
        mem_cmd.rd = 1'b1;
        mem_addr   = nb_addr;
        step_nxt   = step_r + 3'd1;
        if (step_r == vebc_pkg::STEP_ZP) begin
          state_nxt = vebc_pkg::ST_DRAIN;
        end
      end
      vebc_pkg::ST_DRAIN: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = vebc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = vebc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vebc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= mem_cmd.rd;
    end
  end

  // Request context and accumulated scan state
  always_ff @(posedge clk) begin
    step_r      <= step_nxt;
    rd_center_r <= (state_r == vebc_pkg::ST_IDLE);
    if (accept && is_scan) begin
      addr_r   <= in_addr;
      x_r      <= in_req.cell_x;
      y_r      <= in_req.cell_y;
      z_r      <= in_req.cell_z;
      inside_r <= in_inside;
      face_r   <= in_face;
      kind_r   <= vebc_pkg::KIND_AIR;
      air_r    <= 1'b0;
    end else begin
      kind_r <= fin_kind;
      air_r  <= fin_air;
    end
    if (load_out) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ===== src/voxel_exposed_block_cull_top.sv =====
// Exposed-block culling for one voxel chunk. A load request (func 0) writes a
// block kind into the chunk store and gives no result; loads to a cell
// outside the chunk are dropped. A scan request (func 1) gives one result:
// whether the block is solid and either on a chunk face or next to air, its
// kind, and world coordinates offset by chunk_x/chunk_z times CHUNK_WIDTH.
// The chunk store is a single-port memory read one entry per cycle, so an
// interior scan reads the center on accept and its six neighbors in the read
// state, then drains; a scan on a face or out of range goes straight to drain
// and a load leaves the block idle. Every cell a scan touches must have been
// loaded first. A finished result waits in an output register while the next
// request is taken. Write configuration only while no request is in flight;
// a scan takes the chunk offsets when its result is formed.
module voxel_exposed_block_cull_top #(
  parameter int CHUNK_WIDTH  = vebc_pkg::CHUNK_WIDTH_DEF,
  parameter int CHUNK_HEIGHT = vebc_pkg::CHUNK_HEIGHT_DEF,
  parameter int CHUNK_DEPTH  = vebc_pkg::CHUNK_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  vebc_pkg::in_req_t                 in_req,
  output logic                              out_valid,
  input  logic                              out_stall,
  output vebc_pkg::out_res_t                out_res,
  input  logic                              cfg_we,
  input  logic [vebc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vebc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int DEPTH = CHUNK_WIDTH * CHUNK_HEIGHT * CHUNK_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  logic signed [15:0] chunk_x_r;
  logic signed [15:0] chunk_z_r;

  vebc_pkg::mem_cmd_t mem_cmd;
  logic [AW-1:0]      mem_addr;
  logic [1:0]         mem_wdata;
  logic [1:0]         mem_rdata;

  // Chunk offset registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_x_r <= '0;
      chunk_z_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        vebc_pkg::REG_CHUNK_X: chunk_x_r <= $signed(cfg_data);
        vebc_pkg::REG_CHUNK_Z: chunk_z_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  vebc_ctrl #(
    .CHUNK_WIDTH  (CHUNK_WIDTH),
    .CHUNK_HEIGHT (CHUNK_HEIGHT),
    .CHUNK_DEPTH  (CHUNK_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .chunk_x   (chunk_x_r),
    .chunk_z   (chunk_z_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res),
    .mem_cmd   (mem_cmd),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  vebc_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk       (clk),
    .mem_cmd   (mem_cmd),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

endmodule

// ===== tb/exposed_block_checker.sv =====
`timescale 1ns / 1ps
module exposed_block_checker
  import vebc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_req_t               in_req,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_res_t              out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending_count
);

  localparam int CELL_COUNT = CHUNK_WIDTH_DEF * CHUNK_HEIGHT_DEF * CHUNK_DEPTH_DEF;
  localparam int CELL_AW    = $clog2(CELL_COUNT);

  // Shadow of the chunk store and the chunk offset registers
  logic [1:0]         chunk_kinds [CELL_COUNT];
  logic signed [15:0] chunk_x_q;
  logic signed [15:0] chunk_z_q;
  out_res_t           exposure_queue [$];
  int                 mismatches = 0;

  function automatic logic [CELL_AW-1:0] cell_addr(input int x, input int y, input int z);
    return CELL_AW'((x * CHUNK_HEIGHT_DEF + y) * CHUNK_DEPTH_DEF + z);
  endfunction

  function automatic logic [1:0] kind_at(input int x, input int y, input int z);
    return chunk_kinds[cell_addr(x, y, z)];
  endfunction

  // Work out the result of one scan request from the current store
  function automatic out_res_t predict_exposure(input in_req_t req);
    int         x;
    int         y;
    int         z;
    logic [1:0] here;
    logic       on_face;
    out_res_t   res;
    x = int'(req.cell_x);
    y = int'(req.cell_y);
    z = int'(req.cell_z);
    here = kind_at(x, y, z);
    on_face = (x == 0) || (y == 0) || (z == 0) ||
              (x == CHUNK_WIDTH_DEF - 1) || (y == CHUNK_HEIGHT_DEF - 1) ||
              (z == CHUNK_DEPTH_DEF - 1);
    res.exposed = 1'b0;
    res.kind_out = here;
    if (here != KIND_AIR) begin
      // a solid block on a face is always visible, inside it needs an air neighbor
      if (on_face) begin
        res.exposed = 1'b1;
      end else begin
        res.exposed = (kind_at(x - 1, y, z) == KIND_AIR) || (kind_at(x + 1, y, z) == KIND_AIR) ||
                      (kind_at(x, y - 1, z) == KIND_AIR) || (kind_at(x, y + 1, z) == KIND_AIR) ||
                      (kind_at(x, y, z - 1) == KIND_AIR) || (kind_at(x, y, z + 1) == KIND_AIR);
      end
    end
    // world position wraps to the result width
    res.world_x = 20'(x + int'(chunk_x_q) * CHUNK_WIDTH_DEF);
    res.world_y = req.cell_y;
    res.world_z = 20'(z + int'(chunk_z_q) * CHUNK_WIDTH_DEF);
    return res;
  endfunction

  always @(posedge clk) begin
    out_res_t want;
    if (!rst_n) begin
      chunk_x_q = '0;
      chunk_z_q = '0;
      exposure_queue.delete();
    end else begin
      // track register writes
      if (cfg_we) begin
        if (cfg_index == REG_CHUNK_X) begin
          chunk_x_q = cfg_data;
        end else if (cfg_index == REG_CHUNK_Z) begin
          chunk_z_q = cfg_data;
        end
      end

      // compare an accepted result against the oldest prediction
      if (out_valid && !out_stall) begin
        if (exposure_queue.size() == 0) begin
          $error("scan result with no request pending: %p", out_res);
          mismatches++;
        end else begin
          want = exposure_queue.pop_front();
          if (out_res.exposed !== want.exposed) begin
            $error("exposed: expected %0d, got %0d", want.exposed, out_res.exposed);
            mismatches++;
          end
          if (out_res.kind_out !== want.kind_out) begin
            $error("kind_out: expected %0d, got %0d", want.kind_out, out_res.kind_out);
            mismatches++;
          end
          if (out_res.world_x !== want.world_x) begin
            $error("world_x: expected %0d, got %0d", want.world_x, out_res.world_x);
            mismatches++;
          end
          if (out_res.world_y !== want.world_y) begin
            $error("world_y: expected %0d, got %0d", want.world_y, out_res.world_y);
            mismatches++;
          end
          if (out_res.world_z !== want.world_z) begin
            $error("world_z: expected %0d, got %0d", want.world_z, out_res.world_z);
            mismatches++;
          end
        end
      end

      // apply an accepted request: load updates the store, scan queues a prediction
      if (in_valid && !in_stall) begin
        if (in_req.func == FUNC_LOAD) begin
          chunk_kinds[cell_addr(int'(in_req.cell_x), int'(in_req.cell_y),
                                int'(in_req.cell_z))] = in_req.block_kind;
        end else begin
          exposure_queue.insert(exposure_queue.size(), predict_exposure(in_req));
        end
      end
    end
    fail_count <= mismatches;
    pending_count <= exposure_queue.size();
  end

endmodule

// ===== tb/voxel_exposed_block_cull_top_tb.sv =====
`timescale 1ns / 1ps
module voxel_exposed_block_cull_top_tb;
  import vebc_pkg::*;

  localparam int ITEM_TARGET   = 1700;
  localparam int NUM_PHASES    = 5;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int HOLD_AT       = 500;
  localparam int HOLD_LEN      = 400;
  localparam int CELL_COUNT    = CHUNK_WIDTH_DEF * CHUNK_HEIGHT_DEF * CHUNK_DEPTH_DEF;
  localparam int CELL_AW       = $clog2(CELL_COUNT);

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_req_t               in_req = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_res_t              out_res;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int pending_count;
  int items_sent = 0;
  int cycle_count = 0;
  int hold_cycles = 0;
  bit hold_done = 1'b0;
  bit calm = 1'b0;
  bit loaded [CELL_COUNT];

  voxel_exposed_block_cull_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  exposed_block_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req        (in_req),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_res       (out_res),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver: random stalls, one long hold-off to back up the input side
  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (!hold_done && items_sent >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_cycles <= HOLD_LEN;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 13);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [CELL_AW-1:0] cell_index(input int x, input int y, input int z);
    return CELL_AW'((x * CHUNK_HEIGHT_DEF + y) * CHUNK_DEPTH_DEF + z);
  endfunction

  // Mostly solid so that buried interior blocks show up
  function automatic logic [1:0] random_kind();
    if ($urandom_range(99) < 75) begin
      return 2'($urandom_range(3, 1));
    end
    return KIND_AIR;
  endfunction

  // Pick a coordinate close to base, clamped to the chunk
  function automatic int near(input int base, input int hi);
    int v;
    v = base + int'($urandom_range(4)) - 2;
    if (v < 0) begin
      v = 0;
    end
    if (v > hi) begin
      v = hi;
    end
    return v;
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_request(input in_req_t req);
    while (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= req;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    items_sent++;
  endtask

  task automatic load_cell(input int x, input int y, input int z, input logic [1:0] kind);
    in_req_t req;
    req.func = FUNC_LOAD;
    req.cell_x = 4'(x);
    req.cell_y = 8'(y);
    req.cell_z = 4'(z);
    req.block_kind = kind;
    send_request(req);
    loaded[cell_index(x, y, z)] = 1'b1;
  endtask

  // Load whatever the scan would touch and is still unwritten, then scan
  task automatic scan_cell(input int x, input int y, input int z);
    int      dx [7] = '{0, -1, 1, 0, 0, 0, 0};
    int      dy [7] = '{0, 0, 0, -1, 1, 0, 0};
    int      dz [7] = '{0, 0, 0, 0, 0, -1, 1};
    int      nx;
    int      ny;
    int      nz;
    in_req_t req;
    for (int n = 0; n < 7; n++) begin
      nx = x + dx[n];
      ny = y + dy[n];
      nz = z + dz[n];
      if (nx >= 0 && nx < CHUNK_WIDTH_DEF && ny >= 0 && ny < CHUNK_HEIGHT_DEF &&
          nz >= 0 && nz < CHUNK_DEPTH_DEF) begin
        if (!loaded[cell_index(nx, ny, nz)]) begin
          load_cell(nx, ny, nz, random_kind());
        end
      end
    end
    req.func = FUNC_SCAN;
    req.cell_x = 4'(x);
    req.cell_y = 8'(y);
    req.cell_z = 4'(z);
    req.block_kind = 2'($urandom);
    send_request(req);
  endtask

  // Drop valid, wait for every result, then let a trailing load finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_chunk(input logic [15:0] cx, input logic [15:0] cz);
    cfg_we <= 1'b1;
    cfg_index <= REG_CHUNK_X;
    cfg_data <= cx;
    @(posedge clk);
    cfg_index <= REG_CHUNK_Z;
    cfg_data <= cz;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [15:0] chunk_x_set [NUM_PHASES];
    logic [15:0] chunk_z_set [NUM_PHASES];
    int          fx;
    int          fy;
    int          fz;
    int          goal;

    chunk_x_set = '{16'h7fff, 16'h8000, 16'hffff, 16'($urandom), 16'($urandom)};
    chunk_z_set = '{16'h8000, 16'h7fff, 16'h0001, 16'($urandom), 16'($urandom)};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners and faces are visible whatever surrounds them; air never is
    load_cell(0, 0, 0, 2'd3);
    scan_cell(0, 0, 0);
    load_cell(15, 255, 15, 2'd1);
    scan_cell(15, 255, 15);
    load_cell(0, 255, 15, KIND_AIR);
    scan_cell(0, 255, 15);

    // interior block buried in solid neighbors
    load_cell(8, 100, 8, 2'd2);
    load_cell(7, 100, 8, 2'd1);
    load_cell(9, 100, 8, 2'd3);
    load_cell(8, 99, 8, 2'd1);
    load_cell(8, 101, 8, 2'd2);
    load_cell(8, 100, 7, 2'd3);
    load_cell(8, 100, 9, 2'd1);
    scan_cell(8, 100, 8);

    // open one neighbor to air, then clear the center itself
    load_cell(8, 101, 8, KIND_AIR);
    scan_cell(8, 100, 8);
    load_cell(8, 100, 8, KIND_AIR);
    scan_cell(8, 100, 8);

    // random phases, each under its own chunk offset
    fx = $urandom_range(15);
    fy = $urandom_range(255);
    fz = $urandom_range(15);
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      set_chunk(chunk_x_set[p], chunk_z_set[p]);
      calm = (p == 2);
      goal = items_sent + (ITEM_TARGET - items_sent) / (NUM_PHASES - p);
      while (items_sent < goal) begin
        // move the working region now and then
        if ($urandom_range(99) < 8) begin
          fx = $urandom_range(15);
          fy = $urandom_range(255);
          fz = $urandom_range(15);
        end
        if ($urandom_range(1) == 1) begin
          if ($urandom_range(99) < 65) begin
            scan_cell(near(fx, 15), near(fy, 255), near(fz, 15));
          end else begin
            scan_cell($urandom_range(15), $urandom_range(255), $urandom_range(15));
          end
        end else begin
          if ($urandom_range(99) < 60) begin
            load_cell(near(fx, 15), near(fy, 255), near(fz, 15), random_kind());
          end else begin
            load_cell($urandom_range(15), $urandom_range(255), $urandom_range(15),
                      2'($urandom));
          end
        end
      end
    end

    settle();
    if (fail_count == 0 && pending_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
